FILE: rtl/ybbu_pkg.sv
// Shared package for the 4:2:2 to BGR converter with bottom-up pair indexing.
// Holds field widths, register indexes, color coefficients and the clamp function.
// No dependencies.
package ybbu_pkg;

  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned MaxHeightDef = 2048;

  localparam int unsigned CfgW    = 12;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PixW    = 8;
  localparam int unsigned IndexW  = 21;
  localparam int unsigned SumW    = 18;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;

  localparam logic [CfgW-1:0] FrameWidthRst  = 12'd80;
  localparam logic [CfgW-1:0] FrameHeightRst = 12'd60;

  // Chroma coefficients and offsets, all scaled by 128.
  localparam logic signed [SumW-1:0] CoefRv = 18'sd180;
  localparam logic signed [SumW-1:0] CoefGv = 18'sd91;
  localparam logic signed [SumW-1:0] CoefGu = 18'sd44;
  localparam logic signed [SumW-1:0] CoefBu = 18'sd226;
  localparam logic signed [SumW-1:0] OffR   = 18'sd22906;
  localparam logic signed [SumW-1:0] OffG   = 18'sd17264;
  localparam logic signed [SumW-1:0] OffB   = 18'sd28928;

  // Strobes that move one beat through the two pipeline registers.
  typedef struct packed {
    logic load;     // input beat accepted into the input register
    logic advance;  // input register moves into the result register
  } pipe_ctrl_t;

  // Floor shift by 7, then clamp to 0..255.
  function automatic logic [PixW-1:0] clamp_pix(logic signed [SumW-1:0] sum);
    logic signed [SumW-8:0] q;
    q = sum[SumW-1:7];
    if (q < 0) begin
      return '0;
    end else if (q > 255) begin
      return '1;
    end else begin
      return q[PixW-1:0];
    end
  endfunction

endpackage

FILE: rtl/ybbu_color.sv
// Color path: input register for one macropixel, conversion logic, result register.
// Depends on ybbu_pkg.
module ybbu_color (
  input  logic                     clk_i,
  input  ybbu_pkg::pipe_ctrl_t     ctrl_i,
  input  logic [ybbu_pkg::PixW-1:0] luma_first_i,
  input  logic [ybbu_pkg::PixW-1:0] chroma_blue_i,
  input  logic [ybbu_pkg::PixW-1:0] luma_second_i,
  input  logic [ybbu_pkg::PixW-1:0] chroma_red_i,
  output logic [ybbu_pkg::PixW-1:0] blue_first_o,
  output logic [ybbu_pkg::PixW-1:0] green_first_o,
  output logic [ybbu_pkg::PixW-1:0] red_first_o,
  output logic [ybbu_pkg::PixW-1:0] blue_second_o,
  output logic [ybbu_pkg::PixW-1:0] green_second_o,
  output logic [ybbu_pkg::PixW-1:0] red_second_o
);
  import ybbu_pkg::*;

  logic [PixW-1:0] y0_q, u_q, y1_q, v_q;
  logic signed [SumW-1:0] y0_s, y1_s, u_s, v_s;
  logic signed [SumW-1:0] r_off, g_off, b_off;
  logic [PixW-1:0] b0_q, g0_q, r0_q, b1_q, g1_q, r1_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      y0_q <= luma_first_i;
      u_q  <= chroma_blue_i;
      y1_q <= luma_second_i;
      v_q  <= chroma_red_i;
    end
  end

  always_comb begin
    y0_s  = $signed({{(SumW-PixW){1'b0}}, y0_q});
    y1_s  = $signed({{(SumW-PixW){1'b0}}, y1_q});
    u_s   = $signed({{(SumW-PixW){1'b0}}, u_q});
    v_s   = $signed({{(SumW-PixW){1'b0}}, v_q});
    // The chroma terms are shared by both pixels of the pair.
    r_off = v_s * CoefRv - OffR;
    g_off = OffG - v_s * CoefGv - u_s * CoefGu;
    b_off = u_s * CoefBu - OffB;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      b0_q <= clamp_pix((y0_s <<< 7) + b_off);
      g0_q <= clamp_pix((y0_s <<< 7) + g_off);
      r0_q <= clamp_pix((y0_s <<< 7) + r_off);
      b1_q <= clamp_pix((y1_s <<< 7) + b_off);
      g1_q <= clamp_pix((y1_s <<< 7) + g_off);
      r1_q <= clamp_pix((y1_s <<< 7) + r_off);
    end
  end

  assign blue_first_o   = b0_q;
  assign green_first_o  = g0_q;
  assign red_first_o    = r0_q;
  assign blue_second_o  = b1_q;
  assign green_second_o = g1_q;
  assign red_second_o   = r1_q;

endmodule

FILE: rtl/ybbu_addr.sv
// Position path: column and row counters, bottom-up pair index and end-of-frame flag.
// Depends on ybbu_pkg.
module ybbu_addr #(
  parameter int unsigned MAX_WIDTH  = ybbu_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = ybbu_pkg::MaxHeightDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ybbu_pkg::pipe_ctrl_t                ctrl_i,
  input  logic [$clog2(MAX_WIDTH/2+1)-1:0]    pairs_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     rows_i,
  output logic [ybbu_pkg::IndexW-1:0]         pair_index_o,
  output logic                                frame_done_o
);
  import ybbu_pkg::*;

  localparam int unsigned MaxPairs = MAX_WIDTH / 2;
  localparam int unsigned PairW    = $clog2(MaxPairs + 1);
  localparam int unsigned RowsW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned ColW     = (MaxPairs > 1) ? $clog2(MaxPairs) : 1;
  localparam int unsigned RowW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned ProdW    = RowW + PairW;
  localparam int unsigned AddW     = ((ProdW > ColW) ? ProdW : ColW) + 1;

  logic [ColW-1:0]  col_q, col_d, col_sat, col_s1_q;
  logic [RowW-1:0]  row_q, row_d, row_sat, flip, flip_s1_q;
  logic             last_s1_q, last_q;
  logic [PairW-1:0] pairs_m1;
  logic [RowsW-1:0] rows_m1;
  logic             row_end, row_at_last, frame_end;
  logic [AddW-1:0]  index_sum;
  logic [AddW+IndexW-1:0] index_ext;
  logic [IndexW-1:0] index_q;

  always_comb begin
    pairs_m1    = pairs_i - PairW'(1);
    rows_m1     = rows_i - RowsW'(1);
    // A counter left beyond the end by a size change ends the row or frame.
    row_end     = PairW'(col_q) >= pairs_m1;
    row_at_last = RowsW'(row_q) >= rows_m1;
    frame_end   = row_end && row_at_last;
    col_sat     = row_end ? ColW'(pairs_m1) : col_q;
    row_sat     = row_at_last ? RowW'(rows_m1) : row_q;
    flip        = RowW'(rows_m1) - row_sat;

    col_d = col_q;
    row_d = row_q;
    if (frame_end) begin
      col_d = '0;
      row_d = '0;
    end else if (row_end) begin
      col_d = '0;
      row_d = row_q + RowW'(1);
    end else begin
      col_d = col_q + ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (ctrl_i.load) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      col_s1_q  <= col_sat;
      flip_s1_q <= flip;
      last_s1_q <= frame_end;
    end
  end

  always_comb begin
    index_sum = AddW'(ProdW'(flip_s1_q) * ProdW'(pairs_i)) + AddW'(col_s1_q);
    index_ext = {{IndexW{1'b0}}, index_sum};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      index_q <= index_ext[IndexW-1:0];
      last_q  <= last_s1_q;
    end
  end

  assign pair_index_o = index_q;
  assign frame_done_o = last_q;

endmodule

FILE: rtl/yuv422_to_bgr_bottom_up_top.sv
// Latency: an accepted input beat passes through the input register and then the result register to the output.
// Throughput: one macropixel per cycle; the two pipeline registers keep taking beats
// while the output side is ready, and the input register holds one beat while it stalls.
// Reset (rst_ni low, asynchronous): pipeline empty, counters at the first pair of a
// frame, frame_width 80 and frame_height 60. Configuration writes are taken every cycle.
// Depends on ybbu_pkg, ybbu_color and ybbu_addr.
module yuv422_to_bgr_bottom_up_top #(
  parameter int unsigned MAX_WIDTH  = ybbu_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = ybbu_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ybbu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ybbu_pkg::CfgW-1:0]     cfg_data_i,
  // Input macropixel channel (Y0, U, Y1, V).
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ybbu_pkg::PixW-1:0]     luma_first_i,
  input  logic [ybbu_pkg::PixW-1:0]     chroma_blue_i,
  input  logic [ybbu_pkg::PixW-1:0]     luma_second_i,
  input  logic [ybbu_pkg::PixW-1:0]     chroma_red_i,
  // Result channel: two BGR pixels and their place in the bottom-up bitmap.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ybbu_pkg::PixW-1:0]     blue_first_o,
  output logic [ybbu_pkg::PixW-1:0]     green_first_o,
  output logic [ybbu_pkg::PixW-1:0]     red_first_o,
  output logic [ybbu_pkg::PixW-1:0]     blue_second_o,
  output logic [ybbu_pkg::PixW-1:0]     green_second_o,
  output logic [ybbu_pkg::PixW-1:0]     red_second_o,
  output logic [ybbu_pkg::IndexW-1:0]   pair_index_o,
  output logic                          frame_done_o
);
  import ybbu_pkg::*;

  localparam int unsigned MaxPairs = MAX_WIDTH / 2;
  localparam int unsigned PairW    = $clog2(MaxPairs + 1);
  localparam int unsigned RowsW    = $clog2(MAX_HEIGHT + 1);

  logic [CfgW-1:0]  width_q, height_q;
  logic [CfgW-1:0]  half_width;
  logic [PairW-1:0] pairs;
  logic [RowsW-1:0] rows;
  logic             s1_valid_q, s1_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  pipe_ctrl_t       ctrl;

  // Configuration registers. The port never stalls; writes to unknown indexes
  // are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FrameWidthRst;
      height_q <= FrameHeightRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegFrameWidth:  width_q  <= cfg_data_i;
        RegFrameHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame geometry. Pairs per row is half the width, at least one and at most
  // the configured maximum; rows per frame likewise.
  always_comb begin
    half_width = {1'b0, width_q[CfgW-1:1]};
    if (half_width == '0) begin
      pairs = PairW'(1);
    end else if (32'(half_width) > 32'(MaxPairs)) begin
      pairs = PairW'(MaxPairs);
    end else begin
      pairs = PairW'(half_width);
    end

    if (height_q == '0) begin
      rows = RowsW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      rows = RowsW'(MAX_HEIGHT);
    end else begin
      rows = RowsW'(height_q);
    end
  end

  // Two-register pipeline. The result register frees up when its beat is taken,
  // so a new beat can enter every cycle while the output side keeps pace.
  always_comb begin
    out_free     = !out_valid_q || out_ready_i;
    ctrl.advance = s1_valid_q && out_free;
    in_ready_o   = !s1_valid_q || out_free;
    ctrl.load    = in_valid_i && in_ready_o;

    s1_valid_d = s1_valid_q;
    if (ctrl.load) begin
      s1_valid_d = 1'b1;
    end else if (ctrl.advance) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (ctrl.advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  ybbu_color u_color (
    .clk_i          (clk_i),
    .ctrl_i         (ctrl),
    .luma_first_i   (luma_first_i),
    .chroma_blue_i  (chroma_blue_i),
    .luma_second_i  (luma_second_i),
    .chroma_red_i   (chroma_red_i),
    .blue_first_o   (blue_first_o),
    .green_first_o  (green_first_o),
    .red_first_o    (red_first_o),
    .blue_second_o  (blue_second_o),
    .green_second_o (green_second_o),
    .red_second_o   (red_second_o)
  );

  // Counters advance when a beat is accepted; the bitmap index is formed from the
  // position captured with the input beat and registered with the result.
  ybbu_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .pairs_i      (pairs),
    .rows_i       (rows),
    .pair_index_o (pair_index_o),
    .frame_done_o (frame_done_o)
  );

endmodule

FILE: sim/tb.sv
// Self-checking testbench for yuv422_to_bgr_bottom_up_top: 4:2:2 macropixels in, BGR pairs out.
// It predicts colors, bottom-up pair indexes and frame ends, and checks every result beat.
// Depends on ybbu_pkg and the converter RTL only.
module tb;
  import ybbu_pkg::*;

  // Color conversion constants, all scaled by 128.
  localparam int RvCoef    = 180;
  localparam int GvCoef    = 91;
  localparam int GuCoef    = 44;
  localparam int BuCoef    = 226;
  localparam int RedBias   = 22906;
  localparam int GreenBias = 17264;
  localparam int BlueBias  = 28928;

  localparam int unsigned PairLimit = MaxWidthDef / 2;
  localparam int unsigned RowLimit  = MaxHeightDef;

  // Register indexes that the block has no register behind.
  localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;

  typedef struct packed {
    logic [PixW-1:0] luma_first;
    logic [PixW-1:0] chroma_blue;
    logic [PixW-1:0] luma_second;
    logic [PixW-1:0] chroma_red;
  } macropixel_t;

  typedef struct packed {
    logic [PixW-1:0]   blue_first;
    logic [PixW-1:0]   green_first;
    logic [PixW-1:0]   red_first;
    logic [PixW-1:0]   blue_second;
    logic [PixW-1:0]   green_second;
    logic [PixW-1:0]   red_second;
    logic [IndexW-1:0] pair_index;
    logic              frame_done;
  } bgr_pair_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_data_i  = '0;

  logic            in_valid_i    = 1'b0;
  logic            in_ready_o;
  logic [PixW-1:0] luma_first_i  = '0;
  logic [PixW-1:0] chroma_blue_i = '0;
  logic [PixW-1:0] luma_second_i = '0;
  logic [PixW-1:0] chroma_red_i  = '0;

  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [PixW-1:0]   blue_first_o;
  logic [PixW-1:0]   green_first_o;
  logic [PixW-1:0]   red_first_o;
  logic [PixW-1:0]   blue_second_o;
  logic [PixW-1:0]   green_second_o;
  logic [PixW-1:0]   red_second_o;
  logic [IndexW-1:0] pair_index_o;
  logic              frame_done_o;

  yuv422_to_bgr_bottom_up_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .luma_first_i   (luma_first_i),
    .chroma_blue_i  (chroma_blue_i),
    .luma_second_i  (luma_second_i),
    .chroma_red_i   (chroma_red_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .blue_first_o   (blue_first_o),
    .green_first_o  (green_first_o),
    .red_first_o    (red_first_o),
    .blue_second_o  (blue_second_o),
    .green_second_o (green_second_o),
    .red_second_o   (red_second_o),
    .pair_index_o   (pair_index_o),
    .frame_done_o   (frame_done_o)
  );

  always #5 clk_i = ~clk_i;

  // Macropixels waiting to be driven, and BGR pairs that the block still owes us.
  macropixel_t pixel_queue[$];
  bgr_pair_t   bgr_expect_q[$];

  // Our own copy of the frame registers and the raster counters.
  logic [CfgW-1:0] width_reg  = FrameWidthRst;
  logic [CfgW-1:0] height_reg = FrameHeightRst;
  int unsigned     col_pos    = 0;
  int unsigned     row_pos    = 0;

  // When set, both sides insert random idle bursts.
  bit idle_mode = 1'b0;
  // Set at each rising edge when the current input beat was taken.
  bit in_took   = 1'b0;
  int src_gap   = 0;
  int sink_gap  = 0;

  int mismatches    = 0;
  int pairs_checked = 0;
  int frames_closed = 0;
  int cfg_writes    = 0;
  int items_sent    = 0;

  // Floor division by 128 followed by a clamp to the 8-bit pixel range.
  function automatic logic [PixW-1:0] clamp_channel(int sum);
    int level;
    level = sum >>> 7;
    if (level < 0) return '0;
    if (level > 255) return '1;
    return level[PixW-1:0];
  endfunction

  // Converts one macropixel and advances the raster counters, the way the block should.
  function automatic bgr_pair_t convert_macropixel(macropixel_t px);
    bgr_pair_t   res;
    int          red_add, green_add, blue_add, y0, y1;
    int unsigned pairs, rows, col, row;
    bit          row_end, frame_end;
    y0        = int'(px.luma_first) * 128;
    y1        = int'(px.luma_second) * 128;
    red_add   = RvCoef * int'(px.chroma_red) - RedBias;
    green_add = GreenBias - GvCoef * int'(px.chroma_red) - GuCoef * int'(px.chroma_blue);
    blue_add  = BuCoef * int'(px.chroma_blue) - BlueBias;

    // Degenerate frames are raised to one pair and one row; oversized ones are clipped to the limits.
    pairs = 32'(width_reg) / 2;
    if (pairs < 1) pairs = 1;
    if (pairs > PairLimit) pairs = PairLimit;
    rows = 32'(height_reg);
    if (rows < 1) rows = 1;
    if (rows > RowLimit) rows = RowLimit;

    // Counters left past the end by a register change are saturated for the index.
    col       = (col_pos > pairs - 1) ? pairs - 1 : col_pos;
    row       = (row_pos > rows - 1) ? rows - 1 : row_pos;
    row_end   = col_pos >= pairs - 1;
    frame_end = row_end && (row_pos >= rows - 1);

    res.blue_first   = clamp_channel(y0 + blue_add);
    res.green_first  = clamp_channel(y0 + green_add);
    res.red_first    = clamp_channel(y0 + red_add);
    res.blue_second  = clamp_channel(y1 + blue_add);
    res.green_second = clamp_channel(y1 + green_add);
    res.red_second   = clamp_channel(y1 + red_add);
    res.pair_index   = IndexW'((rows - 1 - row) * pairs + col);
    res.frame_done   = frame_end;

    if (frame_end) begin
      col_pos = 0;
      row_pos = 0;
    end else if (row_end) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return res;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("tb: %s wrong on pair %0d: expected %0d, got %0d",
                 field, pairs_checked, want, got);
      end
    end
  endtask

  // Monitor: checks result beats against the oldest prediction, predicts accepted input
  // beats and mirrors configuration writes. Everything is sampled at the rising edge.
  always @(posedge clk_i) begin : monitor
    bgr_pair_t want;
    in_took <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (bgr_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("tb: result beat with nothing outstanding");
        end else begin
          want = bgr_expect_q.pop_front();
          check_field("blue_first", 32'(want.blue_first), 32'(blue_first_o));
          check_field("green_first", 32'(want.green_first), 32'(green_first_o));
          check_field("red_first", 32'(want.red_first), 32'(red_first_o));
          check_field("blue_second", 32'(want.blue_second), 32'(blue_second_o));
          check_field("green_second", 32'(want.green_second), 32'(green_second_o));
          check_field("red_second", 32'(want.red_second), 32'(red_second_o));
          check_field("pair_index", 32'(want.pair_index), 32'(pair_index_o));
          check_field("frame_done", 32'(want.frame_done), 32'(frame_done_o));
          if (want.frame_done) frames_closed++;
          pairs_checked++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        bgr_expect_q.push_back(convert_macropixel('{luma_first_i, chroma_blue_i,
                                                    luma_second_i, chroma_red_i}));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_writes++;
        case (cfg_index_i)
          RegFrameWidth: begin
            width_reg = cfg_data_i;
          end
          RegFrameHeight: begin
            height_reg = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Pixel driver: holds a beat until it is taken, then either idles for a burst or
  // presents the next queued macropixel. Exactly one assignment to valid per edge.
  always @(negedge clk_i) begin : pixel_driver
    macropixel_t px;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_took) begin
      in_valid_i <= 1'b1;
    end else if (src_gap > 0) begin
      src_gap--;
      in_valid_i <= 1'b0;
    end else if (pixel_queue.size() == 0) begin
      in_valid_i <= 1'b0;
    end else if (idle_mode && $urandom_range(0, 9) == 0) begin
      src_gap = $urandom_range(0, 18);
      in_valid_i <= 1'b0;
    end else begin
      px = pixel_queue.pop_front();
      luma_first_i  <= px.luma_first;
      chroma_blue_i <= px.chroma_blue;
      luma_second_i <= px.luma_second;
      chroma_red_i  <= px.chroma_red;
      in_valid_i    <= 1'b1;
    end
  end

  // Result sink: ready most of the time, with random stall bursts while idle_mode is set.
  always @(negedge clk_i) begin : result_sink
    if (sink_gap > 0) begin
      sink_gap--;
      out_ready_i <= 1'b0;
    end else if (idle_mode && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(0, 18);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_frame(int w, int h);
    write_reg(RegFrameWidth, CfgW'(w));
    write_reg(RegFrameHeight, CfgW'(h));
  endtask

  task automatic queue_pixel(int y0, int u, int y1, int v);
    pixel_queue.push_back('{PixW'(y0), PixW'(u), PixW'(y1), PixW'(v)});
    items_sent++;
  endtask

  // Mostly uniform samples, with the range ends picked more often.
  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic queue_random_pixels(int n);
    repeat (n) queue_pixel(pick_sample(), pick_sample(), pick_sample(), pick_sample());
  endtask

  // Waits until every queued beat has gone in and every result has come out,
  // then lets the two-stage pipeline settle.
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || in_valid_i || bgr_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int w, h, pairs, rows, n;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset sizes (80 x 60) with the range ends of every sample and a few typical values.
    idle_mode = 1'b1;
    queue_pixel(0, 0, 0, 0);
    queue_pixel(255, 255, 255, 255);
    queue_pixel(255, 0, 255, 0);
    queue_pixel(0, 255, 0, 255);
    queue_pixel(16, 128, 235, 128);
    queue_pixel(128, 90, 60, 240);
    wait_idle();

    // Zero width and height: one pair per frame, so every beat ends a frame.
    set_frame(0, 0);
    queue_random_pixels(2);
    wait_idle();
    write_reg(RegFrameWidth, 12'd1);
    queue_random_pixels(1);
    wait_idle();

    // Odd width rounds down to two pairs per row.
    set_frame(5, 2);
    queue_random_pixels(4);
    wait_idle();

    // Oversized frame saturates both dimensions; then shrink the width under a
    // column counter that is already past the new last pair.
    set_frame(4095, 4095);
    queue_random_pixels(5);
    wait_idle();
    write_reg(RegFrameWidth, 12'd4);
    queue_random_pixels(2);
    wait_idle();

    // One pair per row with a tall frame, then shrink the height under the row counter.
    // Writes to the unused indexes must leave both registers alone.
    set_frame(2, 4095);
    queue_random_pixels(4);
    wait_idle();
    write_reg(RegSpareLo, 12'd4095);
    write_reg(RegSpareHi, 12'd0);
    write_reg(RegFrameHeight, 12'd2);
    queue_random_pixels(2);
    wait_idle();

    // Random part: mostly small frames sent whole, sometimes cut short or oversized.
    while (items_sent < 1600) begin
      idle_mode = (items_sent < 1300) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: begin
          w = $urandom_range(2049, 4095);
          h = $urandom_range(0, 4);
        end
        1: begin
          w = $urandom_range(0, 8);
          h = $urandom_range(2049, 4095);
        end
        2: begin
          w = ($urandom_range(0, 1) != 0) ? 2048 : 4094;
          h = 2048;
        end
        default: begin
          w = $urandom_range(0, 24);
          h = $urandom_range(0, 6);
        end
      endcase
      // Now and then change only one register so the counters may sit past the end.
      case ($urandom_range(0, 5))
        0: write_reg(RegFrameWidth, CfgW'(w));
        1: write_reg(RegFrameHeight, CfgW'(h));
        2: begin
          write_reg(($urandom_range(0, 1) != 0) ? RegSpareLo : RegSpareHi,
                    CfgW'($urandom_range(0, 4095)));
          set_frame(w, h);
        end
        default: set_frame(w, h);
      endcase

      pairs = int'(width_reg) / 2;
      if (pairs < 1) pairs = 1;
      if (pairs > PairLimit) pairs = PairLimit;
      rows = int'(height_reg);
      if (rows < 1) rows = 1;
      if (rows > RowLimit) rows = RowLimit;
      if (pairs * rows <= 60) n = pairs * rows * $urandom_range(1, 3);
      else n = $urandom_range(10, 120);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 5);
      queue_random_pixels(n);
      wait_idle();
    end

    wait_idle();
    if (bgr_expect_q.size() != 0) mismatches += bgr_expect_q.size();
    $display("tb: %0d pairs checked over %0d complete frames", pairs_checked, frames_closed);
    $display("tb: %0d register writes, %0d mismatching fields", cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #5000000;
    $display("tb: errors");
    $finish;
  end

endmodule
